// File: hw/rtl/tmre_pkg.sv
`default_nettype none

package tmre_pkg;

    // Field widths
    localparam int PIX_W      = 16;
    localparam int LINE_W     = 16;
    localparam int DIM_W      = 8;
    localparam int MODE_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int BTN_W      = 7;
    localparam int DIGIT_W    = 4;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS  = PIX_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACKING_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SGR_ENABLED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_COLUMNS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_ROWS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COLUMNS  = 3'd6;

    // Configuration reset values
    localparam logic [MODE_W-1:0] RST_TRACKING_MODE = 10'd0;
    localparam logic [DIM_W-1:0]  RST_CELL_WIDTH    = 8'd8;
    localparam logic [DIM_W-1:0]  RST_CELL_HEIGHT   = 8'd16;
    localparam logic [DIM_W-1:0]  RST_VIEW_COLUMNS  = 8'd80;
    localparam logic [DIM_W-1:0]  RST_TERM_ROWS     = 8'd24;
    localparam logic [DIM_W-1:0]  RST_TERM_COLUMNS  = 8'd80;

    // Tracking mode from which drags are reported
    localparam logic [MODE_W-1:0] DRAG_MODE = 10'd1002;

    // Event actions
    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_MOVE    = 2'd2;
    localparam logic [1:0] ACT_WHEEL   = 2'd3;

    // Button identifiers
    localparam logic [1:0] BID_MIDDLE = 2'd1;
    localparam logic [1:0] BID_RIGHT  = 2'd2;

    // Button code constants
    localparam logic [BTN_W-1:0] BTN_WHEEL_UP   = 7'd64;
    localparam logic [BTN_W-1:0] BTN_WHEEL_DOWN = 7'd65;
    localparam logic [BTN_W-1:0] BTN_DRAG       = 7'd32;
    localparam logic [BTN_W-1:0] BTN_MOD_SHIFT  = 7'd4;
    localparam logic [BTN_W-1:0] BTN_MOD_ALT    = 7'd8;
    localparam logic [BTN_W-1:0] BTN_MOD_CTRL   = 7'd16;
    localparam logic [BTN_W-1:0] BTN_X10_REL    = 7'd3;
    localparam logic [8:0]       X10_OFFSET     = 9'd32;

    // Report characters
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UPPER = 8'h4D;
    localparam logic [7:0] CH_LOWER = 8'h6D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Byte slots of an SGR report; leading zero digits are skipped.
    localparam logic [CNT_W-1:0] SLOT_ESC   = 4'd0;
    localparam logic [CNT_W-1:0] SLOT_CSI   = 4'd1;
    localparam logic [CNT_W-1:0] SLOT_INTRO = 4'd2;
    localparam logic [CNT_W-1:0] SLOT_B_H   = 4'd3;
    localparam logic [CNT_W-1:0] SLOT_B_T   = 4'd4;
    localparam logic [CNT_W-1:0] SLOT_B_O   = 4'd5;
    localparam logic [CNT_W-1:0] SLOT_SEP1  = 4'd6;
    localparam logic [CNT_W-1:0] SLOT_C_H   = 4'd7;
    localparam logic [CNT_W-1:0] SLOT_C_T   = 4'd8;
    localparam logic [CNT_W-1:0] SLOT_C_O   = 4'd9;
    localparam logic [CNT_W-1:0] SLOT_SEP2  = 4'd10;
    localparam logic [CNT_W-1:0] SLOT_R_H   = 4'd11;
    localparam logic [CNT_W-1:0] SLOT_R_T   = 4'd12;
    localparam logic [CNT_W-1:0] SLOT_R_O   = 4'd13;
    localparam logic [CNT_W-1:0] SLOT_FINAL = 4'd14;

    // Byte slots of an X10 report
    localparam logic [CNT_W-1:0] SLOT_X_CODE = 4'd3;
    localparam logic [CNT_W-1:0] SLOT_X_COL  = 4'd4;
    localparam logic [CNT_W-1:0] SLOT_X_ROW  = 4'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             div_step;
        logic             check;
        logic             conv;
        logic             load_out;
        logic             load_none;
        logic [CNT_W-1:0] slot;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tracking_on;
        logic emit_bytes;
        logic slot_skip;
        logic slot_last;
        logic out_busy;
    } dp_status_t;

    // Three decimal digits of an 8-bit value
    typedef struct packed {
        logic [DIGIT_W-1:0] h;
        logic [DIGIT_W-1:0] t;
        logic [DIGIT_W-1:0] o;
    } dec_t;

    // Decimal split of a value below 256. The tens digit comes from a
    // multiplication by the reciprocal of ten, exact for values below 100.
    function automatic dec_t to_dec(input logic [7:0] v);
        dec_t        d;
        logic [7:0]  rest;
        logic [14:0] prod;
        logic [6:0]  ones;
        if (v >= 8'd200)
        begin
            d.h  = 4'd2;
            rest = v - 8'd200;
        end
        else if (v >= 8'd100)
        begin
            d.h  = 4'd1;
            rest = v - 8'd100;
        end
        else
        begin
            d.h  = 4'd0;
            rest = v;
        end
        prod = {8'd0, rest[6:0]} * 15'd205;
        d.t  = prod[14:11];
        ones = rest[6:0] - 7'({3'd0, d.t} * 7'd10);
        d.o  = ones[3:0];
        return d;
    endfunction

    // Saturate a report value to one byte.
    function automatic logic [7:0] sat8(input logic [8:0] v);
        return v[8] ? 8'hFF : v[7:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tmre_div.sv
`default_nettype none

module tmre_div import tmre_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             start,
    input  wire logic             step,
    input  wire logic [PIX_W-1:0] dividend,
    input  wire logic [DIM_W-1:0] divisor,
    output logic      [PIX_W-1:0] quotient
);

    logic [PIX_W-1:0] quot_reg;
    logic [DIM_W-1:0] rem_reg;
    logic [DIM_W:0]   trial;
    logic [DIM_W:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quot_reg[PIX_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    // The quotient bits replace the dividend bits as they shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (step)
        begin
            rem_reg  <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quot_reg <= {quot_reg[PIX_W-2:0], fits};
        end
    end

    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tmre_dp.sv
`default_nettype none

module tmre_dp import tmre_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]            action,
    input  wire logic [1:0]            button_id,
    input  wire logic [PIX_W-1:0]      pixel_x,
    input  wire logic [PIX_W-1:0]      pixel_y,
    input  wire logic                  shift_held,
    input  wire logic                  alt_held,
    input  wire logic                  ctrl_held,
    input  wire logic                  wheel_up,
    input  wire logic [LINE_W-1:0]     scroll_top,
    input  wire logic [LINE_W-1:0]     history_lines,
    input  wire logic [LINE_W-1:0]     total_lines,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_byte,
    output logic                       byte_valid,
    output logic                       handled,
    output logic                       last
);

    // Configuration registers
    logic [MODE_W-1:0] tracking_mode_reg;
    logic              sgr_enabled_reg;
    logic [DIM_W-1:0]  cell_width_reg;
    logic [DIM_W-1:0]  cell_height_reg;
    logic [DIM_W-1:0]  view_columns_reg;
    logic [DIM_W-1:0]  term_rows_reg;
    logic [DIM_W-1:0]  term_columns_reg;

    // Captured item
    logic [1:0]        action_reg;
    logic [1:0]        button_id_reg;
    logic              shift_reg;
    logic              alt_reg;
    logic              ctrl_reg;
    logic              wheel_up_reg;
    logic [LINE_W-1:0] scroll_top_reg;
    logic [LINE_W-1:0] history_reg;
    logic [LINE_W-1:0] total_reg;
    logic              handled_reg;

    // Button state
    logic              pressed_valid_reg;
    logic [1:0]        pressed_reg;

    // Report values and digits
    logic [DIM_W-1:0]  row_reg;
    logic [DIM_W-1:0]  col_reg;
    logic [BTN_W-1:0]  btn_reg;
    logic              emit_reg;
    dec_t              btn_dec_reg;
    dec_t              col_dec_reg;
    dec_t              row_dec_reg;

    // Output register
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              byte_valid_reg;
    logic              handled_out_reg;
    logic              last_reg;

    logic [DIM_W-1:0]  cw_eff;
    logic [DIM_W-1:0]  ch_eff;
    logic [PIX_W-1:0]  xq;
    logic [PIX_W-1:0]  yq;

    logic [LINE_W-1:0] rmax;
    logic [LINE_W:0]   crow_sum;
    logic [LINE_W-1:0] crow;
    logic [LINE_W+1:0] row_full;
    logic              row_ok;
    logic [DIM_W-1:0]  cmax;
    logic [DIM_W-1:0]  ccol;
    logic [DIM_W:0]    col9;
    logic              col_ok;
    logic              in_range;

    logic [BTN_W-1:0]  btn_base;
    logic [BTN_W-1:0]  btn;
    logic              pv_new;
    logic [1:0]        pb_new;
    logic [1:0]        press_sel;
    logic              emit_new;

    logic [7:0]        slot_byte;
    logic              slot_skip;
    logic              slot_last;
    logic [BTN_W-1:0]  x10_code;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_mode_reg <= RST_TRACKING_MODE;
            sgr_enabled_reg   <= 1'b0;
            cell_width_reg    <= RST_CELL_WIDTH;
            cell_height_reg   <= RST_CELL_HEIGHT;
            view_columns_reg  <= RST_VIEW_COLUMNS;
            term_rows_reg     <= RST_TERM_ROWS;
            term_columns_reg  <= RST_TERM_COLUMNS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRACKING_MODE: tracking_mode_reg <= cfg_data;
                REG_SGR_ENABLED:   sgr_enabled_reg   <= cfg_data[0];
                REG_CELL_WIDTH:    cell_width_reg    <= cfg_data[DIM_W-1:0];
                REG_CELL_HEIGHT:   cell_height_reg   <= cfg_data[DIM_W-1:0];
                REG_VIEW_COLUMNS:  view_columns_reg  <= cfg_data[DIM_W-1:0];
                REG_TERM_ROWS:     term_rows_reg     <= cfg_data[DIM_W-1:0];
                REG_TERM_COLUMNS:  term_columns_reg  <= cfg_data[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg     <= action;
            button_id_reg  <= button_id;
            shift_reg      <= shift_held;
            alt_reg        <= alt_held;
            ctrl_reg       <= ctrl_held;
            wheel_up_reg   <= wheel_up;
            scroll_top_reg <= scroll_top;
            history_reg    <= history_lines;
            total_reg      <= total_lines;
            handled_reg    <= status.tracking_on;
        end
    end

    // A cell size of zero counts as one pixel.
    assign cw_eff = (cell_width_reg == '0) ? 8'd1 : cell_width_reg;
    assign ch_eff = (cell_height_reg == '0) ? 8'd1 : cell_height_reg;

    tmre_div u_div_x
    (
        .clk      (clk),
        .start    (cmd.load),
        .step     (cmd.div_step),
        .dividend (pixel_x),
        .divisor  (cw_eff),
        .quotient (xq)
    );

    tmre_div u_div_y
    (
        .clk      (clk),
        .start    (cmd.load),
        .step     (cmd.div_step),
        .dividend (pixel_y),
        .divisor  (ch_eff),
        .quotient (yq)
    );

    // Clamp the cell to the view and map it to a one-based screen position.
    always_comb
    begin
        rmax     = (total_reg == '0) ? '0 : total_reg - 16'd1;
        crow_sum = {1'b0, scroll_top_reg} + {1'b0, yq};
        crow     = (crow_sum > {1'b0, rmax}) ? rmax : crow_sum[LINE_W-1:0];
        row_full = {2'b00, crow} - {2'b00, history_reg} + 18'd1;
        row_ok   = !row_full[LINE_W+1] && (row_full != '0)
                   && (row_full[LINE_W:0] <= {9'd0, term_rows_reg});
        cmax     = (view_columns_reg == '0) ? '0 : view_columns_reg - 8'd1;
        ccol     = (xq > {8'd0, cmax}) ? cmax : xq[DIM_W-1:0];
        col9     = {1'b0, ccol} + 9'd1;
        col_ok   = col9 <= {1'b0, term_columns_reg};
        in_range = row_ok && col_ok;
    end

    // Button code and the next pressed-button state.
    always_comb
    begin
        pv_new    = pressed_valid_reg;
        pb_new    = pressed_reg;
        btn_base  = '0;
        press_sel = 2'd0;
        if (button_id_reg == BID_RIGHT)
        begin
            press_sel = 2'd2;
        end
        else if (button_id_reg == BID_MIDDLE)
        begin
            press_sel = 2'd1;
        end
        case (action_reg)
            ACT_WHEEL:
            begin
                btn_base = wheel_up_reg ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
            end
            ACT_RELEASE:
            begin
                btn_base = pressed_valid_reg ? {5'd0, pressed_reg} : '0;
                pv_new   = 1'b0;
            end
            ACT_MOVE:
            begin
                if (pressed_valid_reg)
                begin
                    btn_base = {5'd0, pressed_reg} + BTN_DRAG;
                end
                else
                begin
                    pv_new = 1'b1;
                    pb_new = 2'd0;
                end
            end
            default:
            begin
                btn_base = {5'd0, press_sel};
                pv_new   = 1'b1;
                pb_new   = press_sel;
            end
        endcase
        btn = btn_base;
        if (action_reg != ACT_WHEEL)
        begin
            btn = btn_base + (shift_reg ? BTN_MOD_SHIFT : '0)
                + (alt_reg ? BTN_MOD_ALT : '0) + (ctrl_reg ? BTN_MOD_CTRL : '0);
        end
        emit_new = in_range
                   && !((action_reg == ACT_MOVE) && (tracking_mode_reg < DRAG_MODE));
    end

    // Pressed button, changed only by an event inside the screen.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_valid_reg <= 1'b0;
            pressed_reg       <= 2'd0;
        end
        else if (cmd.check && in_range)
        begin
            pressed_valid_reg <= pv_new;
            pressed_reg       <= pb_new;
        end
    end

    // Report values, then their decimal digits.
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            row_reg  <= row_full[DIM_W-1:0];
            col_reg  <= col9[DIM_W-1:0];
            btn_reg  <= btn;
            emit_reg <= emit_new;
        end
        if (cmd.conv)
        begin
            btn_dec_reg <= to_dec({1'b0, btn_reg});
            col_dec_reg <= to_dec(col_reg);
            row_dec_reg <= to_dec(row_reg);
        end
    end

    // Byte of the current slot.
    assign x10_code = (action_reg == ACT_RELEASE) ? BTN_X10_REL : btn_reg;

    always_comb
    begin
        slot_byte = '0;
        slot_skip = 1'b0;
        slot_last = 1'b0;
        if (sgr_enabled_reg)
        begin
            case (cmd.slot)
                SLOT_ESC:   slot_byte = CH_ESC;
                SLOT_CSI:   slot_byte = CH_LBRK;
                SLOT_INTRO: slot_byte = CH_LT;
                SLOT_B_H:
                begin
                    slot_byte = CH_ZERO + {4'd0, btn_dec_reg.h};
                    slot_skip = btn_dec_reg.h == '0;
                end
                SLOT_B_T:
                begin
                    slot_byte = CH_ZERO + {4'd0, btn_dec_reg.t};
                    slot_skip = (btn_dec_reg.h == '0) && (btn_dec_reg.t == '0);
                end
                SLOT_B_O:   slot_byte = CH_ZERO + {4'd0, btn_dec_reg.o};
                SLOT_SEP1:  slot_byte = CH_SEMI;
                SLOT_C_H:
                begin
                    slot_byte = CH_ZERO + {4'd0, col_dec_reg.h};
                    slot_skip = col_dec_reg.h == '0;
                end
                SLOT_C_T:
                begin
                    slot_byte = CH_ZERO + {4'd0, col_dec_reg.t};
                    slot_skip = (col_dec_reg.h == '0) && (col_dec_reg.t == '0);
                end
                SLOT_C_O:   slot_byte = CH_ZERO + {4'd0, col_dec_reg.o};
                SLOT_SEP2:  slot_byte = CH_SEMI;
                SLOT_R_H:
                begin
                    slot_byte = CH_ZERO + {4'd0, row_dec_reg.h};
                    slot_skip = row_dec_reg.h == '0;
                end
                SLOT_R_T:
                begin
                    slot_byte = CH_ZERO + {4'd0, row_dec_reg.t};
                    slot_skip = (row_dec_reg.h == '0) && (row_dec_reg.t == '0);
                end
                SLOT_R_O:   slot_byte = CH_ZERO + {4'd0, row_dec_reg.o};
                SLOT_FINAL:
                begin
                    slot_byte = (action_reg == ACT_RELEASE) ? CH_LOWER : CH_UPPER;
                    slot_last = 1'b1;
                end
                default:    slot_skip = 1'b1;
            endcase
        end
        else
        begin
            case (cmd.slot)
                SLOT_ESC:    slot_byte = CH_ESC;
                SLOT_CSI:    slot_byte = CH_LBRK;
                SLOT_INTRO:  slot_byte = CH_UPPER;
                SLOT_X_CODE: slot_byte = sat8(X10_OFFSET + {2'b00, x10_code});
                SLOT_X_COL:  slot_byte = sat8(X10_OFFSET + {1'b0, col_reg});
                SLOT_X_ROW:
                begin
                    slot_byte = sat8(X10_OFFSET + {1'b0, row_reg});
                    slot_last = 1'b1;
                end
                default:     slot_skip = 1'b1;
            endcase
        end
    end

    // Output register: holds one result item until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out || cmd.load_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg    <= slot_byte;
            byte_valid_reg  <= 1'b1;
            handled_out_reg <= 1'b1;
            last_reg        <= slot_last;
        end
        else if (cmd.load_none)
        begin
            out_byte_reg    <= '0;
            byte_valid_reg  <= 1'b0;
            handled_out_reg <= handled_reg;
            last_reg        <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign handled    = handled_out_reg;
    assign last       = last_reg;

    // Status towards the controller
    assign status.tracking_on = tracking_mode_reg != '0;
    assign status.emit_bytes  = emit_reg;
    assign status.slot_skip   = slot_skip;
    assign status.slot_last   = slot_last;
    assign status.out_busy    = out_valid_reg && !out_ready;

    // The pressed button only moves on the check step.
    a_pressed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.check |=> $stable({pressed_valid_reg, pressed_reg}))
        else $error("pressed button changed outside the check step");

    // An item without a byte is always the only one of its event.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last)
        else $error("empty result item not marked last");

    // An unhandled event never produces report bytes.
    a_unhandled_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !handled |-> !byte_valid)
        else $error("report byte emitted while tracking is off");

endmodule

`default_nettype wire

// File: hw/rtl/tmre_ctrl.sv
`default_nettype none

module tmre_ctrl import tmre_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_CHECK = 6'b000100,
        S_CONV  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_NONE  = 6'b100000
    } state_t;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Next state, counter and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.slot   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.tracking_on ? S_DIV : S_NONE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_CONV;
            end
            S_CONV:
            begin
                cmd.conv   = 1'b1;
                cnt_next   = '0;
                state_next = status.emit_bytes ? S_EMIT : S_NONE;
            end
            S_EMIT:
            begin
                if (status.slot_skip)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    if (status.slot_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_NONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_none = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    // The divider runs exactly its full number of steps.
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (cnt_reg == DIV_LAST) |=> state_reg == S_CHECK)
        else $error("division did not end after its last step");

    // An accepted item starts either the divider or an empty result.
    a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg == S_DIV) || (state_reg == S_NONE))
        else $error("accepted item took an unexpected path");

    // A byte slot waiting on a full output register stays put.
    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && !status.slot_skip && status.out_busy
        |=> (state_reg == S_EMIT) && $stable(cnt_reg))
        else $error("byte slot moved on while the output was stalled");

endmodule

`default_nettype wire

// File: hw/rtl/terminal_mouse_report_encoder_top.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   action .. total_lines, one mouse event
// out       output     out_valid / out_ready out_byte, byte_valid, handled, last
// cfg       input      cfg_we                cfg_index, cfg_data (write only)
//
// One event at a time. With tracking off an event yields a single empty result,
// loaded into the output register once that is free. Otherwise the two pixel
// divisions run side by side in a 16-step bit-serial loop, then a range check
// and a decimal split; an event outside the screen, or a move while the mode
// is below drag mode, gives a single empty result, else the report bytes go out.
// Reset restores the configuration defaults and clears the pressed button.
// A stalled output holds the current byte; the next event is taken once the
// last result of this one is in the output register.
`default_nettype none

module terminal_mouse_report_encoder_top import tmre_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            action,
    input  wire logic [1:0]            button_id,
    input  wire logic [PIX_W-1:0]      pixel_x,
    input  wire logic [PIX_W-1:0]      pixel_y,
    input  wire logic                  shift_held,
    input  wire logic                  alt_held,
    input  wire logic                  ctrl_held,
    input  wire logic                  wheel_up,
    input  wire logic [LINE_W-1:0]     scroll_top,
    input  wire logic [LINE_W-1:0]     history_lines,
    input  wire logic [LINE_W-1:0]     total_lines,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_byte,
    output logic                       byte_valid,
    output logic                       handled,
    output logic                       last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    tmre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Configuration, arithmetic and output register
    tmre_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .button_id     (button_id),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .shift_held    (shift_held),
        .alt_held      (alt_held),
        .ctrl_held     (ctrl_held),
        .wheel_up      (wheel_up),
        .scroll_top    (scroll_top),
        .history_lines (history_lines),
        .total_lines   (total_lines),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .handled       (handled),
        .last          (last)
    );

endmodule

`default_nettype wire
